### src/hgmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgmp_pkg
// Shared widths, register indexes, buffer entry types and saturating adders
// for the hex grid maximum path count unit.
// ----------------------------------------------------------------------------
package hgmp_pkg;

	localparam int VAL_W        = 16;
	localparam int SUM_W        = 32;
	localparam int CNT_W        = 48;
	localparam int ROWS_W       = 16;
	localparam int COLS_W       = 11;
	localparam int CFG_W        = 16;
	localparam int IDX_W        = 1;
	localparam int DEF_MAX_COLS = 1024;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_NUM_ROWS = 1'd0;
	localparam logic [IDX_W-1:0] REG_NUM_COLS = 1'd1;

	// one column of the row buffer: best sum and number of paths reaching it
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	// per-item control carried through the update stage
	typedef struct packed {
		logic first_row;
		logic odd_row;
		logic has_left;
		logic has_right;
		logic fwd_a;
		logic fwd_b;
	} cell_ctl_t;

	// what the update stage hands to the bottom-row reduction
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
		logic             first_col;
		logic             last_row;
		logic             last_col;
	} bot_t;

	function automatic logic [CNT_W-1:0] sat_add_cnt(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

### src/hgmp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgmp_ram
// Generic single write port, single read port RAM with a registered read.
// A read and a write of the same address in one cycle returns the old data.
// ----------------------------------------------------------------------------
module hgmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, and read before write on the same edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### src/hgmp_cell_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgmp_cell_update
// Picks the better of the two predecessors of one cell, merges path counts
// on a tie and adds the cell value to form the new buffer entry.
// ----------------------------------------------------------------------------
module hgmp_cell_update (
	input  wire hgmp_pkg::cell_ctl_t          ctl,
	input  wire logic [hgmp_pkg::VAL_W-1:0]   value,
	input  wire hgmp_pkg::entry_t             ram_a,
	input  wire hgmp_pkg::entry_t             ram_b,
	input  wire hgmp_pkg::entry_t             fwd,
	input  wire hgmp_pkg::entry_t             held,
	output hgmp_pkg::entry_t                  a_eff,
	output hgmp_pkg::entry_t                  result
);
	import hgmp_pkg::*;

	entry_t b_eff;
	entry_t other;
	entry_t best;
	logic   other_ok;

	// take the entry just written where the buffer read was stale
	assign a_eff = ctl.fwd_a ? fwd : ram_a;
	assign b_eff = ctl.fwd_b ? fwd : ram_b;

	// odd rows link from c and c+1, even rows from c-1 and c
	assign other    = ctl.odd_row ? b_eff : held;
	assign other_ok = ctl.odd_row ? ctl.has_right : ctl.has_left;

	// choose the better predecessor, add counts on a tie
	always_comb begin
		best = a_eff;
		if (other_ok && (other.sum > a_eff.sum)) begin
			best = other;
		end else if (other_ok && (other.sum == a_eff.sum)) begin
			best.cnt = sat_add_cnt(a_eff.cnt, other.cnt);
		end
	end

	// top row starts a single path at the cell value
	always_comb begin
		if (ctl.first_row) begin
			result.sum = SUM_W'(value);
			result.cnt = CNT_W'(1);
		end else begin
			result.sum = sat_add_sum(SUM_W'(value), best.sum);
			result.cnt = best.cnt;
		end
	end

endmodule
`default_nettype wire

### src/hgmp_bottom_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgmp_bottom_reduce
// Tracks the maximum and its path count over the bottom row and holds the
// finished result in an output register until it is taken.
// ----------------------------------------------------------------------------
module hgmp_bottom_reduce (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid_s1,
	input  wire hgmp_pkg::bot_t             in_bot,
	output logic                            take,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [hgmp_pkg::SUM_W-1:0]      max_sum,
	output logic [hgmp_pkg::CNT_W-1:0]      path_count
);
	import hgmp_pkg::*;

	logic             valid_s2;
	bot_t             bot_s2;
	logic [SUM_W-1:0] run_max_q;
	logic [CNT_W-1:0] run_cnt_q;
	logic [SUM_W-1:0] nxt_max;
	logic [CNT_W-1:0] nxt_cnt;
	logic             produce;

	assign produce = valid_s2 && bot_s2.last_row && bot_s2.last_col;

	// hold the stage only while a finished result cannot leave
	assign take = !(produce && out_valid && out_stall);

	// fold the bottom-row cell into the running maximum
	always_comb begin
		nxt_max = run_max_q;
		nxt_cnt = run_cnt_q;
		if (bot_s2.first_col || (bot_s2.sum > run_max_q)) begin
			nxt_max = bot_s2.sum;
			nxt_cnt = bot_s2.cnt;
		end else if (bot_s2.sum == run_max_q) begin
			nxt_cnt = sat_add_cnt(run_cnt_q, bot_s2.cnt);
		end
	end

	// advance the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bot_s2 <= in_bot;
		end
	end

	// update the running maximum
	always_ff @(posedge clk) begin
		if (take && valid_s2 && bot_s2.last_row) begin
			run_max_q <= nxt_max;
			run_cnt_q <= nxt_cnt;
		end
	end

	// load and drop the result item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take && produce) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && produce) begin
			max_sum    <= nxt_max;
			path_count <= nxt_cnt;
		end
	end

	a_rise_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(produce))
		else $error("result item appeared without a last cell in the stage");

	a_hold_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> valid_s2 && out_valid)
		else $error("stage held while the output register was free");

endmodule
`default_nettype wire

### src/hex_grid_max_path_count_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_grid_max_path_count_unit
// Maximum top-to-bottom path sum over a staggered grid with the number of
// paths that reach it, computed over a one-row buffer in RAM.
// ----------------------------------------------------------------------------
// Usage: cells enter row-major, top row first, one per cycle with no bubbles
// of its own; the row buffer is held twice in block RAM so that columns c
// and c+1 (both predecessors of a cell in an odd row) are read in the same
// cycle, and the entry written by the previous cell is forwarded past the
// RAM. The result item of a grid passes the update stage, the bottom-row
// reduction stage and the output register, where it stays until taken.
// Input stalls only while a finished result waits to be taken and the next
// grid's bottom row finishes too. Writing num_rows or num_cols restarts the
// grid; do so only while no cell is in flight. There is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module hex_grid_max_path_count_unit #(
	parameter int MAX_COLS = hgmp_pkg::DEF_MAX_COLS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [hgmp_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [hgmp_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [hgmp_pkg::VAL_W-1:0]  cell_value,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [hgmp_pkg::SUM_W-1:0]       max_sum,
	output logic [hgmp_pkg::CNT_W-1:0]       path_count
);
	import hgmp_pkg::*;

	localparam int AW = $clog2(MAX_COLS);
	localparam int CW = $clog2(MAX_COLS + 1);

	logic [ROWS_W-1:0] num_rows_q;
	logic [COLS_W-1:0] num_cols_q;
	logic [ROWS_W-1:0] rows_eff;
	logic [CW-1:0]     cols_eff;

	logic [AW-1:0]     col_q;
	logic [ROWS_W-1:0] row_q;
	logic              has_right;
	logic              last_row;
	logic [AW-1:0]     addr_b;
	logic              accept;
	logic              adv1;
	logic              take2;

	logic              valid_s1;
	logic [AW-1:0]     col_s1;
	logic [VAL_W-1:0]  value_s1;
	logic              last_row_s1;
	logic              last_col_s1;
	cell_ctl_t         ctl_s1;

	entry_t            fwd_q;
	entry_t            held_q;
	entry_t            ram_a;
	entry_t            ram_b;
	entry_t            a_eff;
	entry_t            new_entry;
	bot_t              bot;
	logic              wr_en;

	// clamp the register values to the usable range
	assign rows_eff = (num_rows_q == '0) ? ROWS_W'(1) : num_rows_q;

	always_comb begin
		if (num_cols_q == '0) begin
			cols_eff = CW'(1);
		end else if (32'(num_cols_q) > 32'(MAX_COLS)) begin
			cols_eff = CW'(MAX_COLS);
		end else begin
			cols_eff = CW'(num_cols_q);
		end
	end

	// position of the next cell
	assign has_right = (CW'(col_q) + CW'(1)) < cols_eff;
	assign last_row  = ({1'b0, row_q} + 17'd1) == {1'b0, rows_eff};
	assign addr_b    = has_right ? AW'(col_q + AW'(1)) : col_q;

	assign adv1     = !valid_s1 || take2;
	assign in_stall = !adv1;
	assign accept   = in_valid && adv1;
	assign wr_en    = valid_s1 && adv1;

	// configuration writes restart the grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= ROWS_W'(1);
			num_cols_q <= COLS_W'(1);
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_ROWS: num_rows_q <= cfg_data[ROWS_W-1:0];
				REG_NUM_COLS: num_cols_q <= cfg_data[COLS_W-1:0];
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!has_right) begin
				col_q <= '0;
				row_q <= last_row ? '0 : ROWS_W'(row_q + ROWS_W'(1));
			end else begin
				col_q <= AW'(col_q + AW'(1));
			end
		end
	end

	// row buffer, two copies for two reads a cycle
	hgmp_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_COLS)
	) u_ram_a (
		.clk  (clk),
		.we   (wr_en),
		.waddr(col_s1),
		.wdata(new_entry),
		.re   (accept),
		.raddr(col_q),
		.rdata(ram_a)
	);

	hgmp_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_COLS)
	) u_ram_b (
		.clk  (clk),
		.we   (wr_en),
		.waddr(col_s1),
		.wdata(new_entry),
		.re   (accept),
		.raddr(addr_b),
		.rdata(ram_b)
	);

	// update stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s1   <= '0;
		end else if (accept) begin
			valid_s1         <= 1'b1;
			ctl_s1.first_row <= (row_q == '0);
			ctl_s1.odd_row   <= row_q[0];
			ctl_s1.has_left  <= (col_q != '0);
			ctl_s1.has_right <= has_right;
			ctl_s1.fwd_a     <= wr_en && (col_s1 == col_q);
			ctl_s1.fwd_b     <= wr_en && (col_s1 == addr_b);
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	// update stage payload and the entry being written past the RAM
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_q;
			value_s1    <= cell_value;
			last_row_s1 <= last_row;
			last_col_s1 <= !has_right;
			fwd_q       <= new_entry;
		end
	end

	// keep the previous row's entry of the column to the left
	always_ff @(posedge clk) begin
		if (wr_en) begin
			held_q <= a_eff;
		end
	end

	hgmp_cell_update u_update (
		.ctl   (ctl_s1),
		.value (value_s1),
		.ram_a (ram_a),
		.ram_b (ram_b),
		.fwd   (fwd_q),
		.held  (held_q),
		.a_eff (a_eff),
		.result(new_entry)
	);

	assign bot.sum       = new_entry.sum;
	assign bot.cnt       = new_entry.cnt;
	assign bot.first_col = (col_s1 == '0);
	assign bot.last_row  = last_row_s1;
	assign bot.last_col  = last_col_s1;

	hgmp_bottom_reduce u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid_s1(valid_s1),
		.in_bot     (bot),
		.take       (take2),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.max_sum    (max_sum),
		.path_count (path_count)
	);

	a_fwd_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctl_s1.has_right |-> !(ctl_s1.fwd_a && ctl_s1.fwd_b))
		else $error("one write forwarded into two different columns");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && valid_s1)
		else $error("input stalled with no result waiting");

endmodule
`default_nettype wire
